[rtl/kst_pkg.sv]
// ----------------------------------------------------------------------------
// kst_pkg
// shared types, codes and defaults of the keyed stack table
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int TABLE_SLOTS_DEF = 64;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int MAX_RESULTS     = 8;

  // request codes
  localparam logic [2:0] REQ_REGISTER   = 3'd0;
  localparam logic [2:0] REQ_PUSH       = 3'd1;
  localparam logic [2:0] REQ_POP        = 3'd2;
  localparam logic [2:0] REQ_LIST       = 3'd3;
  localparam logic [2:0] REQ_SORT_KEYS  = 3'd4;
  localparam logic [2:0] REQ_SORT_ITEMS = 3'd5;
  localparam logic [2:0] REQ_CLEAR      = 3'd6;
  localparam logic [2:0] REQ_UNUSED     = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_EMPTY       = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd4;
  localparam logic [2:0] ST_TABLE_EMPTY = 3'd5;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] key;
    logic signed [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] item_out;
    logic [3:0]         position;
    logic               last;
  } out_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CAPTURE, OP_REG, OP_RES_NOT_FOUND, OP_RES_EMPTY, OP_RES_TEMPTY,
    OP_RES_OK, OP_KRD_A, OP_KRD_I, OP_KRD_JM1, OP_INC_A, OP_LRD, OP_LATCH,
    OP_PUSH, OP_POP, OP_RES_POP, OP_LIST_INIT, OP_LIST_RD, OP_RES_LIST,
    OP_EMIT, OP_SK_INIT, OP_SK_HOLD, OP_SK_PLACE, OP_SK_SHIFT, OP_SI_INIT,
    OP_IRD_I, OP_IRD_JM1, OP_SI_HOLD, OP_SI_PLACE, OP_SI_SHIFT, OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       scan_end;
    logic       hit;
    logic       lvl_zero;
    logic       cnt_zero;
    logic       ik_end;
    logic       il_end;
    logic       j_zero;
    logic       k_lt;
    logic       i_lt;
    logic       res_last;
    logic       out_free;
  } stat_t;

endpackage

[rtl/kst_datapath.sv]
// ----------------------------------------------------------------------------
// kst_datapath
// key, level and item memories, counters and result registers
// ----------------------------------------------------------------------------
module kst_datapath #(
  parameter int TABLE_SLOTS = kst_pkg::TABLE_SLOTS_DEF,
  parameter int STACK_DEPTH = kst_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  kst_pkg::cmd_t  cmd,
  input  kst_pkg::in_t   in_data,
  output kst_pkg::stat_t stat,
  output logic           out_valid,
  input  logic           out_ready,
  output kst_pkg::out_t  out_data
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int SW = $clog2(TABLE_SLOTS + 1);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int XW = (SW > LW) ? SW : LW;
  localparam int AW = $clog2(TABLE_SLOTS * STACK_DEPTH);
  localparam int NW = $clog2(kst_pkg::MAX_RESULTS);

  logic [31:0]   key_mem  [TABLE_SLOTS];
  logic [IW-1:0] perm_mem [TABLE_SLOTS];
  logic [LW-1:0] lvl_mem  [TABLE_SLOTS];
  logic [31:0]   item_mem [TABLE_SLOTS*STACK_DEPTH];
  logic [TABLE_SLOTS-1:0] vld_r;

  logic [2:0]    req_r;
  logic [31:0]   key_r, val_r;
  logic [SW-1:0] cnt_r, a_r;
  logic [XW-1:0] i_r, j_r;
  logic [IW-1:0] phys_r;
  logic [LW-1:0] lvl_r, pos_r;
  logic [NW-1:0] n_r;
  logic [31:0]   key_q, item_q, hold_key_r, hold_item_r;
  logic [IW-1:0] perm_q, hold_perm_r;
  logic [LW-1:0] lvl_q;
  logic          vld_q;
  kst_pkg::out_t res_r, out_r;
  logic          out_valid_r;

  logic [XW-1:0] jm1;
  logic [AW-1:0] base;

  assign jm1  = j_r - XW'(1);
  assign base = AW'(phys_r) * AW'(STACK_DEPTH);

  assign stat.req      = req_r;
  assign stat.scan_end = (a_r >= cnt_r);
  assign stat.hit      = (key_q == key_r);
  assign stat.lvl_zero = (lvl_r == '0);
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.ik_end   = (i_r >= XW'(cnt_r));
  assign stat.il_end   = (i_r >= XW'(lvl_r));
  assign stat.j_zero   = (j_r == '0);
  assign stat.k_lt     = ($signed(hold_key_r) < $signed(key_q));
  assign stat.i_lt     = ($signed(hold_item_r) < $signed(item_q));
  assign stat.res_last = res_r.last;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == kst_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.op == kst_pkg::OP_REG && cnt_r != SW'(TABLE_SLOTS)) begin
        cnt_r               <= cnt_r + SW'(1);
        vld_r[cnt_r[IW-1:0]] <= 1'b0;
      end
      if (cmd.op == kst_pkg::OP_PUSH && lvl_r != LW'(STACK_DEPTH)) begin
        vld_r[phys_r] <= 1'b1;
      end
      if (cmd.op == kst_pkg::OP_CLEAR) begin
        vld_r <= '0;
      end
    end
  end

  // memories and payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      kst_pkg::OP_CAPTURE: begin
        req_r <= in_data.req_type;
        key_r <= in_data.key;
        val_r <= in_data.item_value;
        a_r   <= '0;
      end
      kst_pkg::OP_REG: begin
        res_r <= '{status: (cnt_r != SW'(TABLE_SLOTS)) ? kst_pkg::ST_OK
                                                        : kst_pkg::ST_TABLE_FULL,
                   item_out: '0, position: '0, last: 1'b1};
        if (cnt_r != SW'(TABLE_SLOTS)) begin
          key_mem[cnt_r[IW-1:0]]  <= key_r;
          perm_mem[cnt_r[IW-1:0]] <= cnt_r[IW-1:0];
        end
      end
      kst_pkg::OP_RES_NOT_FOUND:
        res_r <= '{status: kst_pkg::ST_NOT_FOUND, item_out: '0, position: '0, last: 1'b1};
      kst_pkg::OP_RES_EMPTY:
        res_r <= '{status: kst_pkg::ST_EMPTY, item_out: '0, position: '0, last: 1'b1};
      kst_pkg::OP_RES_TEMPTY:
        res_r <= '{status: kst_pkg::ST_TABLE_EMPTY, item_out: '0, position: '0, last: 1'b1};
      kst_pkg::OP_RES_OK, kst_pkg::OP_CLEAR:
        res_r <= '{status: kst_pkg::ST_OK, item_out: '0, position: '0, last: 1'b1};
      kst_pkg::OP_KRD_A: begin
        key_q  <= key_mem[a_r[IW-1:0]];
        perm_q <= perm_mem[a_r[IW-1:0]];
      end
      kst_pkg::OP_KRD_I: begin
        key_q  <= key_mem[i_r[IW-1:0]];
        perm_q <= perm_mem[i_r[IW-1:0]];
        j_r    <= i_r;
      end
      kst_pkg::OP_KRD_JM1: begin
        key_q  <= key_mem[jm1[IW-1:0]];
        perm_q <= perm_mem[jm1[IW-1:0]];
      end
      kst_pkg::OP_INC_A: a_r <= a_r + SW'(1);
      kst_pkg::OP_LRD: begin
        phys_r <= perm_q;
        lvl_q  <= lvl_mem[perm_q];
        vld_q  <= vld_r[perm_q];
      end
      kst_pkg::OP_LATCH: begin
        lvl_r <= vld_q ? lvl_q : '0;
        i_r   <= XW'(1);
      end
      kst_pkg::OP_PUSH: begin
        res_r <= '{status: (lvl_r != LW'(STACK_DEPTH)) ? kst_pkg::ST_OK
                                                        : kst_pkg::ST_FULL,
                   item_out: '0, position: '0, last: 1'b1};
        if (lvl_r != LW'(STACK_DEPTH)) begin
          item_mem[base + AW'(lvl_r)] <= val_r;
          lvl_mem[phys_r]             <= lvl_r + LW'(1);
        end
      end
      kst_pkg::OP_POP: begin
        item_q          <= item_mem[base + AW'(lvl_r - LW'(1))];
        lvl_mem[phys_r] <= lvl_r - LW'(1);
      end
      kst_pkg::OP_RES_POP:
        res_r <= '{status: kst_pkg::ST_OK, item_out: item_q, position: 4'(lvl_r), last: 1'b1};
      kst_pkg::OP_LIST_INIT: begin
        pos_r <= lvl_r;
        n_r   <= '0;
      end
      kst_pkg::OP_LIST_RD: item_q <= item_mem[base + AW'(pos_r - LW'(1))];
      kst_pkg::OP_RES_LIST: begin
        res_r <= '{status: kst_pkg::ST_OK, item_out: item_q, position: 4'(pos_r),
                   last: (pos_r == LW'(1)) || (n_r == NW'(kst_pkg::MAX_RESULTS - 1))};
        pos_r <= pos_r - LW'(1);
        n_r   <= n_r + NW'(1);
      end
      kst_pkg::OP_EMIT: out_r <= res_r;
      kst_pkg::OP_SK_INIT: i_r <= XW'(1);
      kst_pkg::OP_SK_HOLD: begin
        hold_key_r  <= key_q;
        hold_perm_r <= perm_q;
      end
      kst_pkg::OP_SK_PLACE: begin
        key_mem[j_r[IW-1:0]]  <= hold_key_r;
        perm_mem[j_r[IW-1:0]] <= hold_perm_r;
        i_r                   <= i_r + XW'(1);
      end
      kst_pkg::OP_SK_SHIFT: begin
        key_mem[j_r[IW-1:0]]  <= key_q;
        perm_mem[j_r[IW-1:0]] <= perm_q;
        j_r                   <= jm1;
      end
      kst_pkg::OP_SI_INIT: a_r <= '0;
      kst_pkg::OP_IRD_I: begin
        item_q <= item_mem[base + AW'(i_r)];
        j_r    <= i_r;
      end
      kst_pkg::OP_IRD_JM1: item_q <= item_mem[base + AW'(jm1)];
      kst_pkg::OP_SI_HOLD: hold_item_r <= item_q;
      kst_pkg::OP_SI_PLACE: begin
        item_mem[base + AW'(j_r)] <= hold_item_r;
        i_r                       <= i_r + XW'(1);
      end
      kst_pkg::OP_SI_SHIFT: begin
        item_mem[base + AW'(j_r)] <= item_q;
        j_r                       <= jm1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/kst_ctrl.sv]
// ----------------------------------------------------------------------------
// kst_ctrl
// request sequencer: scan, stack access, list and insertion sorts
// ----------------------------------------------------------------------------
module kst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [2:0]     in_req,
  output logic           in_ready,
  input  kst_pkg::stat_t stat,
  output kst_pkg::cmd_t  cmd
);

  typedef enum logic [22:0] {
    S_IDLE     = 23'd1 << 0,
    S_REG      = 23'd1 << 1,
    S_SCAN_RD  = 23'd1 << 2,
    S_SCAN_CMP = 23'd1 << 3,
    S_ACT      = 23'd1 << 4,
    S_DO       = 23'd1 << 5,
    S_POP_OUT  = 23'd1 << 6,
    S_LIST_RD  = 23'd1 << 7,
    S_LIST_OUT = 23'd1 << 8,
    S_EMIT     = 23'd1 << 9,
    S_SORT_CHK = 23'd1 << 10,
    S_SK_OUTER = 23'd1 << 11,
    S_SK_HOLD  = 23'd1 << 12,
    S_SK_RD    = 23'd1 << 13,
    S_SK_CMP   = 23'd1 << 14,
    S_SI_SLOT  = 23'd1 << 15,
    S_SI_PERM  = 23'd1 << 16,
    S_SI_LVL   = 23'd1 << 17,
    S_SI_OUTER = 23'd1 << 18,
    S_SI_HOLD  = 23'd1 << 19,
    S_SI_RD    = 23'd1 << 20,
    S_SI_CMP   = 23'd1 << 21,
    S_CLEAR    = 23'd1 << 22
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = kst_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = kst_pkg::OP_CAPTURE;
          unique case (in_req)
            kst_pkg::REQ_REGISTER: state_nxt = S_REG;
            kst_pkg::REQ_PUSH, kst_pkg::REQ_POP, kst_pkg::REQ_LIST: state_nxt = S_SCAN_RD;
            kst_pkg::REQ_SORT_KEYS, kst_pkg::REQ_SORT_ITEMS: state_nxt = S_SORT_CHK;
            kst_pkg::REQ_CLEAR: state_nxt = S_CLEAR;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_REG: begin
        cmd.op    = kst_pkg::OP_REG;
        state_nxt = S_EMIT;
      end
      S_CLEAR: begin
        cmd.op    = kst_pkg::OP_CLEAR;
        state_nxt = S_EMIT;
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          cmd.op    = kst_pkg::OP_RES_NOT_FOUND;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = kst_pkg::OP_KRD_A;
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.hit) begin
          cmd.op    = kst_pkg::OP_LRD;
          state_nxt = S_ACT;
        end else begin
          cmd.op    = kst_pkg::OP_INC_A;
          state_nxt = S_SCAN_RD;
        end
      end
      S_ACT: begin
        cmd.op    = kst_pkg::OP_LATCH;
        state_nxt = S_DO;
      end
      S_DO: begin
        if (stat.req == kst_pkg::REQ_PUSH) begin
          cmd.op    = kst_pkg::OP_PUSH;
          state_nxt = S_EMIT;
        end else if (stat.lvl_zero) begin
          cmd.op    = kst_pkg::OP_RES_EMPTY;
          state_nxt = S_EMIT;
        end else if (stat.req == kst_pkg::REQ_POP) begin
          cmd.op    = kst_pkg::OP_POP;
          state_nxt = S_POP_OUT;
        end else begin
          cmd.op    = kst_pkg::OP_LIST_INIT;
          state_nxt = S_LIST_RD;
        end
      end
      S_POP_OUT: begin
        cmd.op    = kst_pkg::OP_RES_POP;
        state_nxt = S_EMIT;
      end
      S_LIST_RD: begin
        cmd.op    = kst_pkg::OP_LIST_RD;
        state_nxt = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        cmd.op    = kst_pkg::OP_RES_LIST;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = kst_pkg::OP_EMIT;
          state_nxt = stat.res_last ? S_IDLE : S_LIST_RD;
        end
      end
      S_SORT_CHK: begin
        if (stat.cnt_zero) begin
          cmd.op    = kst_pkg::OP_RES_TEMPTY;
          state_nxt = S_EMIT;
        end else if (stat.req == kst_pkg::REQ_SORT_KEYS) begin
          cmd.op    = kst_pkg::OP_SK_INIT;
          state_nxt = S_SK_OUTER;
        end else begin
          cmd.op    = kst_pkg::OP_SI_INIT;
          state_nxt = S_SI_SLOT;
        end
      end
      S_SK_OUTER: begin
        if (stat.ik_end) begin
          cmd.op    = kst_pkg::OP_RES_OK;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = kst_pkg::OP_KRD_I;
          state_nxt = S_SK_HOLD;
        end
      end
      S_SK_HOLD: begin
        cmd.op    = kst_pkg::OP_SK_HOLD;
        state_nxt = S_SK_RD;
      end
      S_SK_RD: begin
        if (stat.j_zero) begin
          cmd.op    = kst_pkg::OP_SK_PLACE;
          state_nxt = S_SK_OUTER;
        end else begin
          cmd.op    = kst_pkg::OP_KRD_JM1;
          state_nxt = S_SK_CMP;
        end
      end
      S_SK_CMP: begin
        if (stat.k_lt) begin
          cmd.op    = kst_pkg::OP_SK_SHIFT;
          state_nxt = S_SK_RD;
        end else begin
          cmd.op    = kst_pkg::OP_SK_PLACE;
          state_nxt = S_SK_OUTER;
        end
      end
      S_SI_SLOT: begin
        if (stat.scan_end) begin
          cmd.op    = kst_pkg::OP_RES_OK;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = kst_pkg::OP_KRD_A;
          state_nxt = S_SI_PERM;
        end
      end
      S_SI_PERM: begin
        cmd.op    = kst_pkg::OP_LRD;
        state_nxt = S_SI_LVL;
      end
      S_SI_LVL: begin
        cmd.op    = kst_pkg::OP_LATCH;
        state_nxt = S_SI_OUTER;
      end
      S_SI_OUTER: begin
        if (stat.il_end) begin
          cmd.op    = kst_pkg::OP_INC_A;
          state_nxt = S_SI_SLOT;
        end else begin
          cmd.op    = kst_pkg::OP_IRD_I;
          state_nxt = S_SI_HOLD;
        end
      end
      S_SI_HOLD: begin
        cmd.op    = kst_pkg::OP_SI_HOLD;
        state_nxt = S_SI_RD;
      end
      S_SI_RD: begin
        if (stat.j_zero) begin
          cmd.op    = kst_pkg::OP_SI_PLACE;
          state_nxt = S_SI_OUTER;
        end else begin
          cmd.op    = kst_pkg::OP_IRD_JM1;
          state_nxt = S_SI_CMP;
        end
      end
      S_SI_CMP: begin
        if (stat.i_lt) begin
          cmd.op    = kst_pkg::OP_SI_SHIFT;
          state_nxt = S_SI_RD;
        end else begin
          cmd.op    = kst_pkg::OP_SI_PLACE;
          state_nxt = S_SI_OUTER;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/keyed_stack_table.sv]
// ----------------------------------------------------------------------------
// keyed_stack_table
// key slots with a bounded stack of item ids each, linear key lookup
// ----------------------------------------------------------------------------
//
//  channel  ports                       word
//  in       in_valid in_ready in_data   req_type, key, item_value
//  out      out_valid out_ready out_data status, item_out, position, last
//
//  one request at a time; in_ready is high only while the sequencer is idle
//  push/pop/list: slots are scanned in order up to and including the hit,
//  then the row level is read and latched before the push, pop or list;
//  list emits one word per listed item; register and clear need no scan
//  sort keys / sort items: insertion sort, a memory read per compare/shift
//  (one memory read port), so quadratic in slots or stack level
//  out_data is a register; a stalled out_ready holds the sequencer in emit
//  synchronous active-low reset empties the table; no clearing pass needed
//
module keyed_stack_table #(
  parameter int TABLE_SLOTS = kst_pkg::TABLE_SLOTS_DEF,
  parameter int STACK_DEPTH = kst_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output kst_pkg::out_t out_data
);

  // command and status between sequencer and datapath
  kst_pkg::cmd_t  cmd;
  kst_pkg::stat_t stat;

  kst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_data.req_type),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memories: keys and slot-to-row map by slot, levels and items by row
  kst_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/keyed_stack_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_stack_table_checker
// watches both channels, predicts every result word and compares it
// ----------------------------------------------------------------------------
module keyed_stack_table_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  kst_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  kst_pkg::out_t out_data,
  output int            errors,
  output int            pending,
  output int            words_seen
);

  localparam int SLOTS = kst_pkg::TABLE_SLOTS_DEF;
  localparam int DEPTH = kst_pkg::STACK_DEPTH_DEF;

  logic signed [31:0] slot_key [SLOTS];
  logic signed [31:0] slot_item [SLOTS][DEPTH];
  int                 slot_level [SLOTS];
  int                 used_slots;
  kst_pkg::out_t      expected_words [$];

  function automatic kst_pkg::out_t make_word(logic [2:0] st, logic signed [31:0] item,
                                              int pos, logic lst);
    kst_pkg::out_t w;
    w.status   = st;
    w.item_out = item;
    w.position = pos[3:0];
    w.last     = lst;
    return w;
  endfunction

  function automatic int find_key(logic signed [31:0] k);
    for (int i = 0; i < used_slots; i++)
      if (slot_key[i] == k) return i;
    return -1;
  endfunction

  task automatic sort_slots_by_key();
    logic signed [31:0] k;
    logic signed [31:0] row [DEPTH];
    int lv, j;
    for (int i = 1; i < used_slots; i++) begin
      k  = slot_key[i];
      lv = slot_level[i];
      row = slot_item[i];
      j = i;
      while (j > 0 && k < slot_key[j-1]) begin
        slot_key[j]   = slot_key[j-1];
        slot_level[j] = slot_level[j-1];
        slot_item[j]  = slot_item[j-1];
        j--;
      end
      slot_key[j]   = k;
      slot_level[j] = lv;
      slot_item[j]  = row;
    end
  endtask

  task automatic sort_every_stack();
    logic signed [31:0] v;
    int j;
    for (int s = 0; s < used_slots; s++)
      for (int i = 1; i < slot_level[s]; i++) begin
        v = slot_item[s][i];
        j = i;
        while (j > 0 && v < slot_item[s][j-1]) begin
          slot_item[s][j] = slot_item[s][j-1];
          j--;
        end
        slot_item[s][j] = v;
      end
  endtask

  task automatic predict_request(kst_pkg::in_t w);
    int s, lv, n;
    case (w.req_type)
      kst_pkg::REQ_REGISTER: begin
        if (used_slots >= SLOTS) begin
          expected_words.push_back(make_word(kst_pkg::ST_TABLE_FULL, 0, 0, 1'b1));
        end else begin
          slot_key[used_slots]   = w.key;
          slot_level[used_slots] = 0;
          used_slots++;
          expected_words.push_back(make_word(kst_pkg::ST_OK, 0, 0, 1'b1));
        end
      end
      kst_pkg::REQ_PUSH, kst_pkg::REQ_POP, kst_pkg::REQ_LIST: begin
        s = find_key(w.key);
        if (s < 0) begin
          expected_words.push_back(make_word(kst_pkg::ST_NOT_FOUND, 0, 0, 1'b1));
        end else begin
          lv = slot_level[s];
          if (w.req_type == kst_pkg::REQ_PUSH) begin
            if (lv >= DEPTH) begin
              expected_words.push_back(make_word(kst_pkg::ST_FULL, 0, 0, 1'b1));
            end else begin
              slot_item[s][lv] = w.item_value;
              slot_level[s]    = lv + 1;
              expected_words.push_back(make_word(kst_pkg::ST_OK, 0, 0, 1'b1));
            end
          end else if (lv == 0) begin
            expected_words.push_back(make_word(kst_pkg::ST_EMPTY, 0, 0, 1'b1));
          end else if (w.req_type == kst_pkg::REQ_POP) begin
            expected_words.push_back(make_word(kst_pkg::ST_OK, slot_item[s][lv-1], lv,
                                               1'b1));
            slot_level[s] = lv - 1;
          end else begin
            n = 0;
            for (int i = lv; i > 0 && n < kst_pkg::MAX_RESULTS; i--) begin
              expected_words.push_back(make_word(kst_pkg::ST_OK, slot_item[s][i-1], i,
                                                 (i == 1 || n == kst_pkg::MAX_RESULTS - 1)));
              n++;
            end
          end
        end
      end
      kst_pkg::REQ_SORT_KEYS, kst_pkg::REQ_SORT_ITEMS: begin
        if (used_slots == 0) begin
          expected_words.push_back(make_word(kst_pkg::ST_TABLE_EMPTY, 0, 0, 1'b1));
        end else begin
          if (w.req_type == kst_pkg::REQ_SORT_KEYS) sort_slots_by_key();
          else sort_every_stack();
          expected_words.push_back(make_word(kst_pkg::ST_OK, 0, 0, 1'b1));
        end
      end
      kst_pkg::REQ_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_level[i] = 0;
        expected_words.push_back(make_word(kst_pkg::ST_OK, 0, 0, 1'b1));
      end
      default: ;  // unused code, no word
    endcase
  endtask

  always @(posedge clk) begin
    kst_pkg::out_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      used_slots = 0;
      for (int i = 0; i < SLOTS; i++) slot_level[i] = 0;
      expected_words.delete();
      errors     <= 0;
      words_seen <= 0;
    end else begin
      if (in_valid && in_ready) predict_request(in_data);
      if (out_valid && out_ready) begin
        words_seen <= words_seen + 1;
        if (expected_words.size() == 0) begin
          $error("unexpected word: status %0d item %0d pos %0d last %0b",
                 out_data.status, out_data.item_out, out_data.position, out_data.last);
          bad++;
        end else begin
          want = expected_words.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            bad++;
          end
          if (out_data.item_out !== want.item_out) begin
            $error("item_out: expected %0d, got %0d", want.item_out, out_data.item_out);
            bad++;
          end
          if (out_data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_data.position);
            bad++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
    pending <= expected_words.size();
  end

endmodule

[tb/keyed_stack_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_stack_table_test
// drives directed then random requests into the keyed stack table with
// random idling on both channels; the checker predicts and compares
// ----------------------------------------------------------------------------
module keyed_stack_table_test;

  localparam int  RANDOM_WORDS = 240;
  localparam int  CALM_TAIL    = 40;
  localparam longint CYCLE_LIMIT = 3000000;  // sorts of a full table dominate

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  kst_pkg::in_t   in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  kst_pkg::out_t  out_data;

  int     errors, pending, words_seen;
  bit     calm = 1'b0;           // no idling on either side while set
  int     stall_left = 0;
  longint cycles = 0;
  int     sent_by_req [8];

  logic signed [31:0] key_pool [8];

  always #2 clk = ~clk;

  keyed_stack_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  keyed_stack_table_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending), .words_seen(words_seen)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: out_ready drops in random stall bursts unless calm is set
  always @(posedge clk) begin
    int n;
    if (stall_left != 0) n = stall_left - 1;
    else if (!calm && rst_n && $urandom_range(0, 5) == 0) n = $urandom_range(1, 12);
    else n = 0;
    stall_left <= n;
    out_ready  <= (n == 0);
  end

  // one request word; valid stays high into the next word when there is no gap
  task automatic send_word(logic [2:0] req, logic signed [31:0] k, logic signed [31:0] v);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.req_type   <= req;
    in_data.key        <= k;
    in_data.item_value <= v;
    sent_by_req[req]++;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 9) < 9) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $urandom_range(0, 3);  // ties exercise sort stability
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18)      send_word(kst_pkg::REQ_REGISTER, pick_key(), $urandom);
    else if (r < 50) send_word(kst_pkg::REQ_PUSH, pick_key(), pick_value());
    else if (r < 68) send_word(kst_pkg::REQ_POP, pick_key(), $urandom);
    else if (r < 84) send_word(kst_pkg::REQ_LIST, pick_key(), $urandom);
    else if (r < 88) send_word(kst_pkg::REQ_SORT_KEYS, pick_key(), $urandom);
    else if (r < 92) send_word(kst_pkg::REQ_SORT_ITEMS, pick_key(), $urandom);
    else if (r < 95) send_word(kst_pkg::REQ_CLEAR, $urandom, $urandom);
    else             send_word(kst_pkg::REQ_UNUSED, $urandom, $urandom);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) sent_by_req[i] = 0;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table cases, unknown keys, extremes, full stack, sorts
    send_word(kst_pkg::REQ_UNUSED, 32'sh7fff_ffff, 32'sh8000_0000);
    send_word(kst_pkg::REQ_SORT_KEYS, 0, 0);
    send_word(kst_pkg::REQ_SORT_ITEMS, 0, 0);
    send_word(kst_pkg::REQ_CLEAR, 0, 0);
    send_word(kst_pkg::REQ_PUSH, 5, 1);
    send_word(kst_pkg::REQ_POP, 5, 0);
    send_word(kst_pkg::REQ_LIST, 5, 0);
    send_word(kst_pkg::REQ_REGISTER, 32'sh7fff_ffff, 0);
    send_word(kst_pkg::REQ_REGISTER, 32'sh8000_0000, 0);
    send_word(kst_pkg::REQ_REGISTER, 32'sh7fff_ffff, 0);  // duplicate key
    send_word(kst_pkg::REQ_POP, 32'sh8000_0000, 0);       // empty stack
    send_word(kst_pkg::REQ_LIST, 32'sh8000_0000, 0);
    send_word(kst_pkg::REQ_PUSH, 32'sh8000_0000, 32'sh7fff_ffff);
    send_word(kst_pkg::REQ_PUSH, 32'sh8000_0000, 32'sh8000_0000);
    send_word(kst_pkg::REQ_PUSH, 32'sh8000_0000, -1);
    send_word(kst_pkg::REQ_PUSH, 32'sh8000_0000, 0);
    for (int i = 0; i < 4; i++) send_word(kst_pkg::REQ_PUSH, 32'sh8000_0000, 3);
    send_word(kst_pkg::REQ_PUSH, 32'sh8000_0000, 9);      // stack full
    send_word(kst_pkg::REQ_LIST, 32'sh8000_0000, 0);
    send_word(kst_pkg::REQ_PUSH, 32'sh7fff_ffff, 42);
    send_word(kst_pkg::REQ_SORT_ITEMS, 0, 0);
    send_word(kst_pkg::REQ_LIST, 32'sh8000_0000, 0);
    send_word(kst_pkg::REQ_SORT_KEYS, 0, 0);
    send_word(kst_pkg::REQ_POP, 32'sh8000_0000, 0);
    send_word(kst_pkg::REQ_CLEAR, 0, 0);
    send_word(kst_pkg::REQ_LIST, 32'sh7fff_ffff, 0);

    // random: calm windows give stretches without idling
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= RANDOM_WORDS - CALM_TAIL) || (n % 90 >= 70);
      if (n == 150) begin
        // fill the table so table-full registrations and big sorts happen
        for (int i = 0; i < 66; i++) send_word(kst_pkg::REQ_REGISTER, pick_key(), $urandom);
      end
      send_random_word();
    end
    in_valid <= 1'b0;

    // let the checker see the last accepted request before waiting on it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d requests, %0d result words checked",
             sent_by_req.sum(), words_seen);
    $display("register %0d push %0d pop %0d list %0d sorts %0d/%0d clear %0d unused %0d",
             sent_by_req[0], sent_by_req[1], sent_by_req[2], sent_by_req[3],
             sent_by_req[4], sent_by_req[5], sent_by_req[6], sent_by_req[7]);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
rtl/kst_pkg.sv
rtl/kst_datapath.sv
rtl/kst_ctrl.sv
rtl/keyed_stack_table.sv
tb/keyed_stack_table_checker.sv
tb/keyed_stack_table_test.sv
